// ----- rtl/core/ps2sc_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2sc_pkg
// Shared types, scancode constants and key lookup tables for the set-1
// scancode to ascii decoder.
// ----------------------------------------------------------------------------
package ps2sc_pkg;

  // scancode constants
  localparam logic [7:0] SC_PREFIX_E0 = 8'hE0;
  localparam logic [7:0] SC_PREFIX_E1 = 8'hE1;
  localparam logic [7:0] SC_CAPS      = 8'h3A;
  localparam logic [7:0] SC_LSHIFT    = 8'h2A;
  localparam logic [7:0] SC_RSHIFT    = 8'h36;
  localparam logic [7:0] SC_CTRL      = 8'h1D;
  localparam logic [7:0] SC_ALT       = 8'h38;
  localparam logic [7:0] SC_REL_BIT   = 8'h80;
  localparam logic [7:0] SC_LSHIFT_RL = SC_LSHIFT | SC_REL_BIT;
  localparam logic [7:0] SC_RSHIFT_RL = SC_RSHIFT | SC_REL_BIT;
  localparam logic [7:0] SC_CTRL_RL   = SC_CTRL | SC_REL_BIT;
  localparam logic [7:0] SC_ALT_RL    = SC_ALT | SC_REL_BIT;

  // table entry codes
  localparam logic [7:0] KEY_NONE     = 8'h00;
  localparam logic [7:0] KEY_SPECIAL  = 8'hFF;
  localparam logic [7:0] KEY_FN_FIRST = 8'h81;
  localparam logic [7:0] KEY_FN_LAST  = 8'h8C;
  localparam logic [7:0] KEY_FN_BASE  = 8'h80;

  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned CONSOLE_W = 4;

  typedef enum logic {
    EV_CHAR   = 1'b0,
    EV_SWITCH = 1'b1
  } event_kind_t;

  // modifier state
  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
  } mods_t;

  // one result transaction
  typedef struct packed {
    event_kind_t            event_kind;
    logic [CHAR_W-1:0]      char_code;
    logic                   ctrl_flag;
    logic                   alt_flag;
    logic [CONSOLE_W-1:0]   console_number;
  } result_t;

  // plain entry of a make code
  function automatic logic [7:0] key_plain(input logic [6:0] code);
    logic [7:0] v;
    unique case (code)
      7'h1E: v = "a";  7'h30: v = "b";  7'h2E: v = "c";  7'h20: v = "d";
      7'h12: v = "e";  7'h21: v = "f";  7'h22: v = "g";  7'h23: v = "h";
      7'h17: v = "i";  7'h24: v = "j";  7'h25: v = "k";  7'h26: v = "l";
      7'h32: v = "m";  7'h31: v = "n";  7'h18: v = "o";  7'h19: v = "p";
      7'h10: v = "q";  7'h13: v = "r";  7'h1F: v = "s";  7'h14: v = "t";
      7'h16: v = "u";  7'h2F: v = "v";  7'h11: v = "w";  7'h2D: v = "x";
      7'h15: v = "y";  7'h2C: v = "z";
      7'h0B: v = "0";  7'h02: v = "1";  7'h03: v = "2";  7'h04: v = "3";
      7'h05: v = "4";  7'h06: v = "5";  7'h07: v = "6";  7'h08: v = "7";
      7'h09: v = "8";  7'h0A: v = "9";
      7'h29: v = 8'h60; 7'h0C: v = 8'h2D; 7'h0D: v = 8'h3D; 7'h2B: v = 8'h5C;
      7'h39: v = 8'h20; 7'h0F: v = 8'h09; 7'h1C: v = 8'h0A; 7'h1A: v = 8'h5B;
      7'h1B: v = 8'h5D; 7'h27: v = 8'h3B; 7'h28: v = 8'h27; 7'h33: v = 8'h2C;
      7'h34: v = 8'h2E; 7'h35: v = 8'h2F; 7'h0E: v = 8'h08;
      // function keys
      7'h3B: v = 8'h81; 7'h3C: v = 8'h82; 7'h3D: v = 8'h83; 7'h3E: v = 8'h84;
      7'h3F: v = 8'h85; 7'h40: v = 8'h86; 7'h41: v = 8'h87; 7'h42: v = 8'h88;
      7'h43: v = 8'h89; 7'h44: v = 8'h8A; 7'h57: v = 8'h8B; 7'h58: v = 8'h8C;
      // navigation and other special keys
      7'h5B, 7'h5C, 7'h5D, 7'h01, 7'h52, 7'h47, 7'h49, 7'h53,
      7'h4F, 7'h51, 7'h48, 7'h4B, 7'h50, 7'h4D: v = KEY_SPECIAL;
      default: v = KEY_NONE;
    endcase
    return v;
  endfunction

  // shifted entry of a make code, ascii keys only
  function automatic logic [7:0] key_shifted(input logic [6:0] code);
    logic [7:0] v;
    unique case (code)
      7'h1E: v = "A";  7'h30: v = "B";  7'h2E: v = "C";  7'h20: v = "D";
      7'h12: v = "E";  7'h21: v = "F";  7'h22: v = "G";  7'h23: v = "H";
      7'h17: v = "I";  7'h24: v = "J";  7'h25: v = "K";  7'h26: v = "L";
      7'h32: v = "M";  7'h31: v = "N";  7'h18: v = "O";  7'h19: v = "P";
      7'h10: v = "Q";  7'h13: v = "R";  7'h1F: v = "S";  7'h14: v = "T";
      7'h16: v = "U";  7'h2F: v = "V";  7'h11: v = "W";  7'h2D: v = "X";
      7'h15: v = "Y";  7'h2C: v = "Z";
      7'h0B: v = 8'h29; 7'h02: v = 8'h21; 7'h03: v = 8'h40; 7'h04: v = 8'h23;
      7'h05: v = 8'h24; 7'h06: v = 8'h25; 7'h07: v = 8'h5E; 7'h08: v = 8'h26;
      7'h09: v = 8'h2A; 7'h0A: v = 8'h28;
      7'h29: v = 8'h7E; 7'h0C: v = 8'h5F; 7'h0D: v = 8'h2B; 7'h2B: v = 8'h7C;
      7'h39: v = 8'h20; 7'h0F: v = 8'h09; 7'h1C: v = 8'h0A; 7'h1A: v = 8'h7B;
      7'h1B: v = 8'h7D; 7'h27: v = 8'h3A; 7'h28: v = 8'h22; 7'h33: v = 8'h3C;
      7'h34: v = 8'h3E; 7'h35: v = 8'h3F; 7'h0E: v = 8'h08;
      default: v = KEY_NONE;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/ps2sc_in_if.sv -----
// ----------------------------------------------------------------------------
// ps2sc_in_if
// Scancode channel: one raw set-1 byte per transaction.
// ----------------------------------------------------------------------------
interface ps2sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

// ----- rtl/core/ps2sc_out_if.sv -----
// ----------------------------------------------------------------------------
// ps2sc_out_if
// Result channel: a typed character or a console switch per transaction.
// ----------------------------------------------------------------------------
interface ps2sc_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [6:0] char_code;
  logic       ctrl_flag;
  logic       alt_flag;
  logic [3:0] console_number;

  modport source (output valid, output event_kind, output char_code, output ctrl_flag,
                  output alt_flag, output console_number, input ready);
  modport sink   (input valid, input event_kind, input char_code, input ctrl_flag,
                  input alt_flag, input console_number, output ready);
endinterface

// ----- rtl/core/ps2sc_decode.sv -----
// ----------------------------------------------------------------------------
// ps2sc_decode
// Combinational decode of one scancode against the modifier state: gives
// the next modifier state and at most one result.
// ----------------------------------------------------------------------------
module ps2sc_decode (
  input  logic [7:0]         code,
  input  ps2sc_pkg::mods_t   mods,
  output ps2sc_pkg::mods_t   mods_nxt,
  output logic               res_valid,
  output ps2sc_pkg::result_t res
);
  import ps2sc_pkg::*;

  logic [6:0] low7;
  logic [7:0] entry;
  logic [7:0] shifted;
  logic [7:0] fn_num;
  logic       is_letter;
  logic       use_shift;
  logic       is_fn;
  logic       is_ignored;

  assign low7    = code[6:0];
  assign entry   = key_plain(low7);
  assign shifted = key_shifted(low7);
  assign fn_num  = entry - KEY_FN_BASE;

  // letters follow shift xor caps, other keys follow shift alone
  assign is_letter = (entry >= 8'h61) && (entry <= 8'h7A);
  assign use_shift = is_letter ? (mods.shift ^ mods.caps) : mods.shift;
  assign is_fn     = (entry >= KEY_FN_FIRST) && (entry <= KEY_FN_LAST);
  assign is_ignored = (code == 8'h00) || (code == SC_PREFIX_E0) || (code == SC_PREFIX_E1);

  // modifier tracking and result selection
  always_comb begin
    mods_nxt           = mods;
    res_valid          = 1'b0;
    res.event_kind     = EV_CHAR;
    res.char_code      = '0;
    res.ctrl_flag      = mods.ctrl;
    res.alt_flag       = mods.alt;
    res.console_number = '0;
    priority if (is_ignored) begin
      mods_nxt = mods;
    end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
      mods_nxt.shift = 1'b1;
    end else if (code == SC_LSHIFT_RL || code == SC_RSHIFT_RL) begin
      mods_nxt.shift = 1'b0;
    end else if (code == SC_CTRL) begin
      mods_nxt.ctrl = 1'b1;
    end else if (code == SC_CTRL_RL) begin
      mods_nxt.ctrl = 1'b0;
    end else if (code == SC_ALT) begin
      mods_nxt.alt = 1'b1;
    end else if (code == SC_ALT_RL) begin
      mods_nxt.alt = 1'b0;
    end else if (code == SC_CAPS) begin
      mods_nxt.caps = ~mods.caps;
    end else if (code[7] || entry == KEY_NONE) begin
      res_valid = 1'b0;
    end else if (!mods.ctrl && mods.alt && is_fn) begin
      // alt plus function key asks for a console switch
      res_valid          = 1'b1;
      res.event_kind     = EV_SWITCH;
      res.ctrl_flag      = 1'b0;
      res.alt_flag       = 1'b1;
      res.console_number = fn_num[CONSOLE_W-1:0];
    end else if (!entry[7]) begin
      res_valid     = 1'b1;
      res.char_code = use_shift ? shifted[CHAR_W-1:0] : entry[CHAR_W-1:0];
    end else begin
      res_valid = 1'b0;
    end
  end

endmodule

// ----- rtl/core/ps2_scancode_to_ascii_decoder.sv -----
// ----------------------------------------------------------------------------
// ps2_scancode_to_ascii_decoder
// Set-1 scancode to ascii decoder with shift, ctrl, alt and caps lock
// tracking and alt plus function key console switch requests.
// ----------------------------------------------------------------------------
//  channel  direction  payload                                     handshake
//  in_ch    sink       scan_byte[7:0]                              valid/ready
//  out_ch   source     event_kind, char_code[6:0], ctrl_flag,      valid/ready
//                      alt_flag, console_number[3:0]
//
//  path: the input register holds the scancode and the result register takes the
//  decoded result and offers it; one transaction per cycle while out_ch.ready stays high.
//  the decode table lookup and modifier update sit between the two registers.
//  reset: rst_n synchronous, clears both valids and all modifier state.
//  stalls: a held result blocks the input register only; in_ch.ready stays
//  high whenever the input register can move on.
// ----------------------------------------------------------------------------
module ps2_scancode_to_ascii_decoder (
  input logic      clk,
  input logic      rst_n,
  ps2sc_in_if.sink   in_ch,
  ps2sc_out_if.source out_ch
);
  import ps2sc_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_code_r, in_code_nxt;
  mods_t      mods_r, mods_nxt, dec_mods;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r, out_res_nxt, dec_res;
  logic       dec_valid;
  logic       advance;
  logic       in_take;

  // decode of the registered scancode
  ps2sc_decode u_decode (
    .code      (in_code_r),
    .mods      (mods_r),
    .mods_nxt  (dec_mods),
    .res_valid (dec_valid),
    .res       (dec_res)
  );

  // handshake control
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  // next values of input stage, modifiers and result stage
  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_code_nxt   = in_code_r;
    mods_nxt      = mods_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
      in_code_nxt  = in_ch.scan_byte;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    if (advance) begin
      mods_nxt      = dec_mods;
      out_valid_nxt = dec_valid;
      out_res_nxt   = dec_res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mods_r      <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      mods_r      <= mods_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_code_r <= in_code_nxt;
    out_res_r <= out_res_nxt;
  end

  // result port
  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_kind     = out_res_r.event_kind;
  assign out_ch.char_code      = out_res_r.char_code;
  assign out_ch.ctrl_flag      = out_res_r.ctrl_flag;
  assign out_ch.alt_flag       = out_res_r.alt_flag;
  assign out_ch.console_number = out_res_r.console_number;

  // a console switch always carries alt only and a console from one to twelve
  a_switch_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.event_kind == EV_SWITCH) |->
      (out_res_r.alt_flag && !out_res_r.ctrl_flag && out_res_r.char_code == '0 &&
       out_res_r.console_number >= 4'd1 && out_res_r.console_number <= 4'd12))
    else $error("console switch with bad fields");

  // a character never names a console
  a_char_console: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.event_kind == EV_CHAR) |-> (out_res_r.console_number == '0))
    else $error("character result with console number");

  // modifiers only move when the input register hands its code on
  a_mods_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(mods_r))
    else $error("modifier state changed without a decode");

  // prefix bytes neither touch modifiers nor make a result
  a_prefix_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (in_code_r == SC_PREFIX_E0 || in_code_r == SC_PREFIX_E1)) |=>
      ($stable(mods_r) && !out_valid_r))
    else $error("prefix byte had an effect");

endmodule
